// ===== rtl/fpsa_pkg.sv =====
// Shared package for the free page stack allocator.
// Holds sizes, command and status codes, and the word types. No dependencies.
`timescale 1ns / 1ps

package fpsa_pkg;

    localparam int ADDR_BITS     = 48;
    localparam int PAGE_SHIFT    = 12;
    localparam int STACK_DEPTH   = 4096;
    localparam int PN_BITS       = ADDR_BITS - PAGE_SHIFT;
    localparam int IDX_BITS      = $clog2(STACK_DEPTH);
    localparam int CNT_BITS      = $clog2(STACK_DEPTH + 1);
    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_ADDR_BITS = 5;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_FREE  = 2'd0;
    localparam t_cmd CMD_ALLOC = 2'd1;
    localparam t_cmd CMD_RANGE = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_BAD   = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;
    localparam t_status ST_FULL  = 2'd3;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_KERNEL_END  = 2'd0;
    localparam t_reg_idx REG_PHYS_TOP    = 2'd1;
    localparam t_reg_idx REG_VIRT_OFFSET = 2'd2;

    typedef struct packed {
        t_cmd                 cmd;
        logic [ADDR_BITS-1:0] page_addr;
        logic [ADDR_BITS-1:0] range_end;
    } t_in_word;

    typedef struct packed {
        t_status              status;
        logic [ADDR_BITS-1:0] alloc_addr;
        logic [CNT_BITS-1:0]  pages_freed;
        logic [CNT_BITS-1:0]  free_count;
    } t_out_word;

    typedef struct packed {
        logic [ADDR_BITS-1:0] kernel_end;
        logic [ADDR_BITS-1:0] phys_top;
        logic [ADDR_BITS-1:0] virt_offset;
    } t_cfg;

    typedef struct packed {
        logic                 we;
        logic [IDX_BITS-1:0]  waddr;
        logic [PN_BITS-1:0]   wdata;
        logic [IDX_BITS-1:0]  raddr;
    } t_mem_req;

    typedef struct packed {
        logic [ADDR_BITS-1:0] diff;
        logic                 borrow;
    } t_sub_res;

endpackage

// ===== rtl/fpsa_cfg.sv =====
// Configuration registers of the page allocator behind an APB-style port.
// Depends on fpsa_pkg.
`timescale 1ns / 1ps

module fpsa_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fpsa_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [fpsa_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [fpsa_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                               pready,
    output fpsa_pkg::t_cfg                     o_cfg
);
    import fpsa_pkg::*;

    logic [ADDR_BITS-1:0] r_kernel_end;
    logic [ADDR_BITS-1:0] r_phys_top;
    logic [ADDR_BITS-1:0] r_virt_offset;
    t_reg_idx             reg_idx;
    logic                 wr_en;

    // Registers sit every eight bytes.
    assign reg_idx = paddr[CFG_ADDR_BITS-1:3];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_end  <= '0;
            r_phys_top    <= '0;
            r_virt_offset <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_KERNEL_END:  r_kernel_end  <= pwdata[ADDR_BITS-1:0];
                REG_PHYS_TOP:    r_phys_top    <= pwdata[ADDR_BITS-1:0];
                REG_VIRT_OFFSET: r_virt_offset <= pwdata[ADDR_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_KERNEL_END:  prdata = CFG_DATA_BITS'(r_kernel_end);
            REG_PHYS_TOP:    prdata = CFG_DATA_BITS'(r_phys_top);
            REG_VIRT_OFFSET: prdata = CFG_DATA_BITS'(r_virt_offset);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.kernel_end  = r_kernel_end;
    assign o_cfg.phys_top    = r_phys_top;
    assign o_cfg.virt_offset = r_virt_offset;

endmodule

// ===== rtl/fpsa_sub.sv =====
// Shared address subtractor: one wide subtract with borrow out, used for
// every compare and for the physical address. Depends on fpsa_pkg.
`timescale 1ns / 1ps

module fpsa_sub (
    input  logic [fpsa_pkg::ADDR_BITS-1:0] i_a,
    input  logic [fpsa_pkg::ADDR_BITS-1:0] i_b,
    output fpsa_pkg::t_sub_res             o_res
);
    import fpsa_pkg::*;

    logic [ADDR_BITS:0] full;

    assign full         = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.diff   = full[ADDR_BITS-1:0];
    assign o_res.borrow = full[ADDR_BITS];

endmodule

// ===== rtl/fpsa_stack.sv =====
// Free page stack storage: one write port and one registered read port.
// Depends on fpsa_pkg.
`timescale 1ns / 1ps

module fpsa_stack (
    input  logic                         i_clk,
    input  fpsa_pkg::t_mem_req           i_req,
    output logic [fpsa_pkg::PN_BITS-1:0] o_rdata
);
    import fpsa_pkg::*;

    logic [PN_BITS-1:0] r_mem [STACK_DEPTH];
    logic [PN_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fpsa_ctrl.sv =====
// Command sequencer of the page allocator: drives the shared subtractor
// step by step, pushes and pops the stack, and holds the output word.
// Depends on fpsa_pkg.
`timescale 1ns / 1ps

module fpsa_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  fpsa_pkg::t_in_word             i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output fpsa_pkg::t_out_word            o_out_word,
    input  fpsa_pkg::t_cfg                 i_cfg,
    output logic [fpsa_pkg::ADDR_BITS-1:0] o_sub_a,
    output logic [fpsa_pkg::ADDR_BITS-1:0] o_sub_b,
    input  fpsa_pkg::t_sub_res             i_sub,
    output fpsa_pkg::t_mem_req             o_mem,
    input  logic [fpsa_pkg::PN_BITS-1:0]   i_rdata
);
    import fpsa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP,
        S_ROUND,
        S_RANGE_CMP,
        S_CHK_KE,
        S_CHK_PHYS,
        S_CHK_TOP,
        S_PUSH,
        S_FIN
    } t_state;

    t_state               r_state, n_state;
    t_cmd                 r_cmd, n_cmd;
    logic [PN_BITS-1:0]   r_pn, n_pn;
    logic                 r_low, n_low;
    logic [ADDR_BITS-1:0] r_vend, n_vend;
    logic [ADDR_BITS-1:0] r_phys, n_phys;
    logic [CNT_BITS-1:0]  r_top, n_top;
    logic [CNT_BITS-1:0]  r_freed, n_freed;
    t_status              r_status, n_status;
    logic [ADDR_BITS-1:0] r_alloc, n_alloc;
    logic                 r_out_valid, n_out_valid;
    t_out_word            r_out_word, n_out_word;

    logic                 in_acc;
    logic [ADDR_BITS-1:0] cur_addr;
    logic [PN_BITS:0]     pn_inc;
    logic [CNT_BITS-1:0]  top_dec;
    logic                 stack_full;

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign cur_addr   = {r_pn, {PAGE_SHIFT{1'b0}}};
    assign pn_inc     = {1'b0, r_pn} + {{PN_BITS{1'b0}}, 1'b1};
    assign top_dec    = r_top - {{(CNT_BITS-1){1'b0}}, 1'b1};
    assign stack_full = (r_top == CNT_BITS'(STACK_DEPTH));

    // Operand selection for the shared subtractor.
    always_comb begin
        case (r_state)
            S_RANGE_CMP: begin
                o_sub_a = r_vend;
                o_sub_b = cur_addr;
            end
            S_CHK_KE: begin
                o_sub_a = cur_addr;
                o_sub_b = i_cfg.kernel_end;
            end
            S_CHK_PHYS: begin
                o_sub_a = cur_addr;
                o_sub_b = i_cfg.virt_offset;
            end
            S_CHK_TOP: begin
                o_sub_a = r_phys;
                o_sub_b = i_cfg.phys_top;
            end
            default: begin
                o_sub_a = cur_addr;
                o_sub_b = r_vend;
            end
        endcase
    end

    always_comb begin
        o_mem.we    = (r_state == S_PUSH) && !stack_full;
        o_mem.waddr = r_top[IDX_BITS-1:0];
        o_mem.wdata = r_pn;
        o_mem.raddr = top_dec[IDX_BITS-1:0];
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_pn        = r_pn;
        n_low       = r_low;
        n_vend      = r_vend;
        n_phys      = r_phys;
        n_top       = r_top;
        n_freed     = r_freed;
        n_status    = r_status;
        n_alloc     = r_alloc;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd    = i_in_word.cmd;
                    n_pn     = i_in_word.page_addr[ADDR_BITS-1:PAGE_SHIFT];
                    n_low    = |i_in_word.page_addr[PAGE_SHIFT-1:0];
                    n_vend   = i_in_word.range_end;
                    n_freed  = '0;
                    n_alloc  = '0;
                    n_status = ST_OK;
                    case (i_in_word.cmd)
                        CMD_FREE: begin
                            if (|i_in_word.page_addr[PAGE_SHIFT-1:0]) begin
                                n_status = ST_BAD;
                                n_state  = S_FIN;
                            end else begin
                                n_state  = S_CHK_KE;
                            end
                        end
                        CMD_ALLOC: begin
                            // The read of the top entry is issued now.
                            if (r_top == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_FIN;
                            end else begin
                                n_top    = top_dec;
                                n_state  = S_POP;
                            end
                        end
                        CMD_RANGE: n_state = S_ROUND;
                        default:   n_state = S_FIN;
                    endcase
                end
            end
            S_POP: begin
                n_alloc = {i_rdata, {PAGE_SHIFT{1'b0}}};
                n_state = S_FIN;
            end
            S_ROUND: begin
                if (r_low) begin
                    n_pn = pn_inc[PN_BITS-1:0];
                    // Rounding past the top of the address space leaves no page.
                    n_state = pn_inc[PN_BITS] ? S_FIN : S_RANGE_CMP;
                end else begin
                    n_state = S_RANGE_CMP;
                end
            end
            S_RANGE_CMP: begin
                // A whole page fits when range_end - addr is at least one page.
                if (i_sub.borrow || (i_sub.diff[ADDR_BITS-1:PAGE_SHIFT] == '0)) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_CHK_KE;
                end
            end
            S_CHK_KE: begin
                if (i_sub.borrow) begin
                    n_status = ST_BAD;
                    n_state  = S_FIN;
                end else begin
                    n_state  = S_CHK_PHYS;
                end
            end
            S_CHK_PHYS: begin
                n_phys  = i_sub.diff;
                n_state = S_CHK_TOP;
            end
            S_CHK_TOP: begin
                if (!i_sub.borrow) begin
                    n_status = ST_BAD;
                    n_state  = S_FIN;
                end else begin
                    n_state  = S_PUSH;
                end
            end
            S_PUSH: begin
                if (stack_full) begin
                    n_status = ST_FULL;
                    n_state  = S_FIN;
                end else begin
                    n_top   = r_top + {{(CNT_BITS-1){1'b0}}, 1'b1};
                    n_freed = r_freed + {{(CNT_BITS-1){1'b0}}, 1'b1};
                    if (r_cmd == CMD_RANGE) begin
                        n_pn    = pn_inc[PN_BITS-1:0];
                        n_state = S_RANGE_CMP;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid            = 1'b1;
                    n_out_word.status      = r_status;
                    n_out_word.alloc_addr  = r_alloc;
                    n_out_word.pages_freed = r_freed;
                    n_out_word.free_count  = r_top;
                    n_state                = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_top       <= n_top;
            r_out_valid <= n_out_valid;
        end
        r_cmd      <= n_cmd;
        r_pn       <= n_pn;
        r_low      <= n_low;
        r_vend     <= n_vend;
        r_phys     <= n_phys;
        r_freed    <= n_freed;
        r_status   <= n_status;
        r_alloc    <= n_alloc;
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== rtl/free_page_stack_allocator_core.sv =====
// Free page stack allocator, top level; uses fpsa_pkg, fpsa_cfg, fpsa_sub, fpsa_stack, fpsa_ctrl.
// Alloc pops the stack; a single free checks alignment, kernel_end and phys_top before it
// pushes; a range free rounds its start up and pushes page by page until the range ends,
// a page is rejected, the stack is full or the rounded start wraps.
// Output stalls delay the result. A new word is accepted the cycle after the output loads.
// Synchronous active-low reset empties the stack, clears the configuration registers and the output valid.
`timescale 1ns / 1ps

module free_page_stack_allocator_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  fpsa_pkg::t_in_word                 i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output fpsa_pkg::t_out_word                o_out_word,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fpsa_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [fpsa_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [fpsa_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                               pready
);
    import fpsa_pkg::*;

    t_cfg                 cfg;
    logic [ADDR_BITS-1:0] sub_a;
    logic [ADDR_BITS-1:0] sub_b;
    t_sub_res             sub_res;
    t_mem_req             mem_req;
    logic [PN_BITS-1:0]   mem_rdata;

    fpsa_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fpsa_sub u_sub (
        .i_a   (sub_a),
        .i_b   (sub_b),
        .o_res (sub_res)
    );

    fpsa_stack u_stack (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    fpsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg       (cfg),
        .o_sub_a     (sub_a),
        .o_sub_b     (sub_b),
        .i_sub       (sub_res),
        .o_mem       (mem_req),
        .i_rdata     (mem_rdata)
    );

endmodule

// ===== rtl/fpsa_chk.sv =====
// Port-level checker for the free page stack allocator, bound to the top.
// Depends on fpsa_pkg.
`timescale 1ns / 1ps

module fpsa_chk (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  o_in_stall,
    input  logic                  o_out_valid,
    input  logic                  i_out_stall,
    input  fpsa_pkg::t_out_word   o_out_word
);
    import fpsa_pkg::*;

    // A held output word must not change.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("output word changed while stalled");

    // The block is busy in the cycle after it takes a word.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted twice in a row");

    // An empty report leaves no pages and no address.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.status == ST_EMPTY)) |->
        ((o_out_word.alloc_addr == '0) && (o_out_word.free_count == '0)))
        else $error("empty status with pages or address");

    // Pushed pages are still on the stack, which never exceeds its depth.
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
        ((o_out_word.pages_freed <= o_out_word.free_count) &&
         (o_out_word.free_count <= CNT_BITS'(STACK_DEPTH))))
        else $error("page counts out of range");

    // An address is returned only by a successful alloc, which frees nothing.
    a_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.alloc_addr != '0)) |->
        ((o_out_word.status == ST_OK) && (o_out_word.pages_freed == '0)))
        else $error("address returned with a free or a failure");

endmodule

bind free_page_stack_allocator_core fpsa_chk u_fpsa_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

// ===== tb/sv/page_stack_checker.sv =====
// Checker for the free page stack allocator: watches both word channels and the
// register port, predicts every result word and compares it. Uses fpsa_pkg.
`timescale 1ns / 1ps

module page_stack_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  fpsa_pkg::t_in_word                 i_in_word,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  fpsa_pkg::t_out_word                i_out_word,
    input  logic                               i_psel,
    input  logic                               i_penable,
    input  logic                               i_pwrite,
    input  logic                               i_pready,
    input  logic [fpsa_pkg::CFG_ADDR_BITS-1:0] i_paddr,
    input  logic [fpsa_pkg::CFG_DATA_BITS-1:0] i_pwdata,
    output int                                 o_mismatches,
    output int                                 o_words_due
);
    import fpsa_pkg::*;

    localparam logic [63:0] PAGE_BYTES = 64'd1 << PAGE_SHIFT;
    localparam logic [63:0] ADDR_MASK  = (64'd1 << ADDR_BITS) - 64'd1;

    logic [PN_BITS-1:0]   page_numbers [STACK_DEPTH];
    int                   depth;
    logic [ADDR_BITS-1:0] kernel_end;
    logic [ADDR_BITS-1:0] phys_top;
    logic [ADDR_BITS-1:0] virt_offset;
    t_out_word            due_words [$];

    function automatic logic page_rejected(input logic [ADDR_BITS-1:0] va);
        logic [ADDR_BITS-1:0] pa;
        // The physical address wraps modulo the address width.
        pa = va - virt_offset;
        return (va[PAGE_SHIFT-1:0] != '0) || (va < kernel_end) || (pa >= phys_top);
    endfunction

    function automatic t_status push_page(input logic [ADDR_BITS-1:0] va);
        if (page_rejected(va)) return ST_BAD;
        if (depth >= STACK_DEPTH) return ST_FULL;
        page_numbers[depth] = va[ADDR_BITS-1:PAGE_SHIFT];
        depth++;
        return ST_OK;
    endfunction

    function automatic t_out_word apply_command(input t_in_word w);
        t_out_word   res;
        t_status     st;
        logic [63:0] pg;
        logic [63:0] last;
        logic        carry;
        res = '0;
        res.status = ST_OK;
        case (w.cmd)
            CMD_FREE: begin
                res.status = push_page(w.page_addr);
                if (res.status == ST_OK) res.pages_freed = CNT_BITS'(1);
            end
            CMD_ALLOC: begin
                if (depth == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    depth--;
                    res.alloc_addr = {page_numbers[depth], {PAGE_SHIFT{1'b0}}};
                end
            end
            CMD_RANGE: begin
                pg = 64'(w.page_addr) & ~(PAGE_BYTES - 64'd1);
                carry = 1'b0;
                if (w.page_addr[PAGE_SHIFT-1:0] != '0) begin
                    // Rounding up past the top of the address space leaves no pages.
                    if (pg > ADDR_MASK - PAGE_BYTES) carry = 1'b1;
                    else pg = pg + PAGE_BYTES;
                end
                if (!carry && 64'(w.range_end) >= PAGE_BYTES) begin
                    last = 64'(w.range_end) - PAGE_BYTES;
                    while (pg <= last && res.status == ST_OK) begin
                        st = push_page(pg[ADDR_BITS-1:0]);
                        if (st == ST_OK) begin
                            res.pages_freed = res.pages_freed + 1'b1;
                            pg = pg + PAGE_BYTES;
                        end else begin
                            res.status = st;
                        end
                    end
                end
            end
            default: ;
        endcase
        res.free_count = CNT_BITS'(depth);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            depth = 0;
            kernel_end = '0;
            phys_top = '0;
            virt_offset = '0;
            due_words.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[CFG_ADDR_BITS-1:3]))
                    REG_KERNEL_END:  kernel_end = i_pwdata[ADDR_BITS-1:0];
                    REG_PHYS_TOP:    phys_top = i_pwdata[ADDR_BITS-1:0];
                    REG_VIRT_OFFSET: virt_offset = i_pwdata[ADDR_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (due_words.size() == 0) begin
                    $display("%0t ns: result word with none expected, expected nothing, actual %h",
                             $time, i_out_word);
                    o_mismatches++;
                end else begin
                    want = due_words.pop_front();
                    check_field("status", 64'(want.status), 64'(i_out_word.status));
                    check_field("alloc_addr", 64'(want.alloc_addr),
                                64'(i_out_word.alloc_addr));
                    check_field("pages_freed", 64'(want.pages_freed),
                                64'(i_out_word.pages_freed));
                    check_field("free_count", 64'(want.free_count),
                                64'(i_out_word.free_count));
                end
            end
            if (i_in_valid && !i_in_stall) due_words.push_back(apply_command(i_in_word));
        end
        o_words_due = due_words.size();
    end

endmodule

// ===== tb/sv/tb_free_page_stack_allocator_core.sv =====
// Testbench top for free_page_stack_allocator_core: clock, reset, register writes,
// command words and output stalls. Uses fpsa_pkg and page_stack_checker.
`timescale 1ns / 1ps

module tb_free_page_stack_allocator_core;
    import fpsa_pkg::*;

    localparam t_cmd                 CMD_NONE     = 2'd3;
    localparam logic [ADDR_BITS-1:0] PAGE_BYTES   = ADDR_BITS'(1) << PAGE_SHIFT;
    localparam logic [ADDR_BITS-1:0] ADDR_MAX     = '1;
    localparam int                   QUIET_LIMIT  = 100000;
    localparam int                   RANDOM_WORDS = 170;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    t_in_word                 in_word = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    t_out_word                out_word;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr = '0;
    logic [CFG_DATA_BITS-1:0] pwdata = '0;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    int                       mismatches;
    int                       words_due;
    int                       gap_pct = 23;
    int                       stall_pct = 68;
    int                       quiet_cycles = 0;
    logic [ADDR_BITS-1:0]     win_lo = '0;
    int                       win_pages = 64;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    free_page_stack_allocator_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    page_stack_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_mismatches (mismatches),
        .o_words_due  (words_due)
    );

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Ends the run when neither channel has moved a word for too long.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_word(input t_in_word w);
        logic stalled;
        while ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end while (stalled);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (words_due != 0);
        repeat (16) @(posedge clk);
    endtask

    task automatic configure(input logic [ADDR_BITS-1:0] kend, input logic [ADDR_BITS-1:0] ptop,
                             input logic [ADDR_BITS-1:0] voff);
        logic [ADDR_BITS-1:0] vals [3];
        t_reg_idx             regs [3];
        vals = '{kend, ptop, voff};
        regs = '{REG_KERNEL_END, REG_PHYS_TOP, REG_VIRT_OFFSET};
        wait_drained();
        // psel stays high from one access into the next setup cycle.
        for (int i = 0; i < 3; i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {regs[i], 3'b000};
            pwdata  <= CFG_DATA_BITS'(vals[i]);
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Good pages are exactly the pages from lo up to lo + pages pages.
    task automatic set_window(input logic [ADDR_BITS-1:0] lo, input logic [ADDR_BITS-1:0] offs,
                              input int pages);
        configure(lo, offs + PAGE_BYTES * pages, lo - offs);
        win_lo = lo;
        win_pages = pages;
    endtask

    task automatic random_window(input int pages);
        logic [63:0] r1;
        logic [63:0] r2;
        r1 = {$urandom, $urandom};
        r2 = {$urandom, $urandom};
        set_window({1'b0, r1[46:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}},
                   {8'd0, r2[39:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}}, pages);
    endtask

    function automatic logic [ADDR_BITS-1:0] pick_addr();
        logic [63:0] noise;
        int          r;
        noise = {$urandom, $urandom};
        r = $urandom_range(99);
        if (r < 70) return win_lo + PAGE_BYTES * $urandom_range(win_pages - 1);
        if (r < 80) return noise[ADDR_BITS-1:0];
        if (r < 88) return win_lo - PAGE_BYTES * $urandom_range(1, 3);
        if (r < 94) return win_lo + PAGE_BYTES * (win_pages + $urandom_range(2));
        return win_lo + PAGE_BYTES * $urandom_range(win_pages - 1) + (noise[PAGE_SHIFT-1:0] | 1'b1);
    endfunction

    function automatic t_in_word random_word();
        t_in_word    w;
        logic [63:0] n1;
        logic [63:0] n2;
        int          r;
        n1 = {$urandom, $urandom};
        n2 = {$urandom, $urandom};
        r = $urandom_range(99);
        w.cmd = CMD_ALLOC;
        w.page_addr = n1[ADDR_BITS-1:0];
        w.range_end = n2[ADDR_BITS-1:0];
        if (r < 30) begin
            w.cmd = CMD_FREE;
            w.page_addr = pick_addr();
        end else if (r < 70) begin
            w.cmd = CMD_ALLOC;
        end else if (r < 95) begin
            w.cmd = CMD_RANGE;
            w.page_addr = pick_addr();
            if (n1[63]) w.page_addr[PAGE_SHIFT-1:0] = n1[PAGE_SHIFT-1:0];
            if (r < 88) begin
                w.range_end = w.page_addr + PAGE_BYTES * $urandom_range(6) + n2[PAGE_SHIFT-1:0];
            end else if (r < 91) begin
                w.range_end = w.page_addr + PAGE_BYTES * $urandom_range(40);
            end else begin
                // An end at or below the start gives an empty range.
                w.range_end = w.page_addr - PAGE_BYTES * $urandom_range(3) - n2[PAGE_SHIFT-1:0];
            end
        end else begin
            w.cmd = CMD_NONE;
        end
        return w;
    endfunction

    task automatic random_words(input int count);
        for (int i = 0; i < count; i++) send_word(random_word());
    endtask

    initial begin
        logic [ADDR_BITS-1:0] k;
        logic [63:0]          r;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers at reset reject every page.
        send_word('{CMD_ALLOC, '0, '0});
        send_word('{CMD_FREE, 48'h1000, '0});
        send_word('{CMD_NONE, ADDR_MAX, ADDR_MAX});
        send_word('{CMD_RANGE, '0, 48'h3000});

        set_window(48'h0000_8010_0000, 48'h10_0000, 64);
        k = win_lo;
        send_word('{CMD_FREE, k, '0});
        send_word('{CMD_FREE, k + 1, '0});
        send_word('{CMD_FREE, k - PAGE_BYTES, '0});
        send_word('{CMD_FREE, k + PAGE_BYTES * 64, '0});
        send_word('{CMD_FREE, 48'h7FFF_F000, '0});
        send_word('{CMD_ALLOC, '0, '0});
        send_word('{CMD_RANGE, k + 48'h123, k + PAGE_BYTES * 4 + 5});
        send_word('{CMD_RANGE, k + PAGE_BYTES * 60, k + PAGE_BYTES * 70});
        send_word('{CMD_RANGE, k + PAGE_BYTES + 1, k + PAGE_BYTES * 2 + 7});
        send_word('{CMD_RANGE, '0, 48'hFFF});
        send_word('{CMD_ALLOC, '0, '0});
        send_word('{CMD_ALLOC, '0, '0});

        configure('0, ADDR_MAX, '0);
        send_word('{CMD_FREE, '0, '0});
        send_word('{CMD_FREE, ADDR_MAX - 48'hFFF, '0});
        send_word('{CMD_FREE, ADDR_MAX, '0});
        send_word('{CMD_RANGE, ADDR_MAX, ADDR_MAX});
        send_word('{CMD_RANGE, ADDR_MAX - 48'h1FFF, ADDR_MAX});
        send_word('{CMD_ALLOC, '0, '0});

        configure(ADDR_MAX, ADDR_MAX, '0);
        send_word('{CMD_FREE, ADDR_MAX - 48'hFFF, '0});

        random_window(64);
        random_words(RANDOM_WORDS);

        gap_pct = 68;
        stall_pct = 23;
        configure('0, ADDR_MAX, ADDR_MAX);
        r = {$urandom, $urandom};
        win_lo = {r[ADDR_BITS-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
        win_pages = 64;
        random_words(RANDOM_WORDS);

        gap_pct = 0;
        stall_pct = 0;
        random_window(64);
        random_words(RANDOM_WORDS - 10);

        // Fill the stack to the top, then hit it with frees and a range.
        random_window(8192);
        k = win_lo;
        send_word('{CMD_RANGE, k, k + PAGE_BYTES * 4200});
        send_word('{CMD_FREE, k + PAGE_BYTES * 5000, ADDR_MAX});
        send_word('{CMD_RANGE, k + PAGE_BYTES * 5000, k + PAGE_BYTES * 5003});
        send_word('{CMD_FREE, k + 1, '0});
        send_word('{CMD_ALLOC, '0, '0});
        send_word('{CMD_ALLOC, '0, '0});

        wait_drained();
        @(negedge clk);
        if (mismatches == 0 && words_due == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== free_page_stack_allocator_core.f =====
rtl/fpsa_pkg.sv
rtl/fpsa_cfg.sv
rtl/fpsa_sub.sv
rtl/fpsa_stack.sv
rtl/fpsa_ctrl.sv
rtl/free_page_stack_allocator_core.sv
rtl/fpsa_chk.sv
tb/sv/page_stack_checker.sv
tb/sv/tb_free_page_stack_allocator_core.sv
